[rtl/aht_pkg.sv]
package aht_pkg;

  localparam int SAMPLE_W   = 18;
  localparam int TEMP_W     = 12;
  localparam int CAL_W      = 10;
  localparam int NREADS_W   = 5;
  localparam int DUR_W      = 32;
  localparam int INTERVAL_W = 32;
  localparam int EVENT_W    = 2;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
  localparam logic [EVENT_W-1:0] EV_OFF  = 2'd1;
  localparam logic [EVENT_W-1:0] EV_ON   = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_NUM_READS     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_TEMP      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_TEMP      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CALIBRATION   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SAVE_INTERVAL = 3'd4;

  localparam logic [NREADS_W-1:0]   NUM_READS_RST     = 5'd4;
  localparam logic [NREADS_W-1:0]   NUM_READS_DFLT    = 5'd4;
  localparam logic [TEMP_W-1:0]     MIN_TEMP_RST      = 12'd180;
  localparam logic [TEMP_W-1:0]     MAX_TEMP_RST      = 12'd220;
  localparam logic [CAL_W-1:0]      CAL_RST           = 10'd0;
  localparam logic [INTERVAL_W-1:0] SAVE_INTERVAL_RST = 32'd600;

  localparam int DIV_SCALE = 100;

  typedef struct packed {
    logic tick_en;
    logic read_en;
    logic div_start;
    logic fin_load;
  } aht_cmd_t;

  typedef struct packed {
    logic meas_done;
    logic div_done;
  } aht_sts_t;

endpackage

[rtl/averaging_hysteresis_thermostat_unit.sv]
// channel | dir | handshake               | payload
// in_     | in  | in_tvalid / in_tready   | tdata: sample_value; tuser: cmd
// out_    | out | out_tvalid / out_tready | tdata: temperature .. save_due
// cfg_    | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// Ticks and readings that do not complete a measurement leave the unit idle and ready.
// A completing reading goes through the load, divide and finish steps; the divide
// is the one-bit-per-cycle restoring divider over the sum magnitude.
// Synchronous active-low reset; no clearing pass. Config is always ready.
// A result waits in the output register; input is not ready during the divide,
// and stays stalled in the finish step while the previous result is still held.
module averaging_hysteresis_thermostat_unit #(
  parameter int MAX_READS  = 16,
  parameter int TICK_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [aht_pkg::IN_DATA_W-1:0]    in_tdata,   // [17:0] sample_value
  input  logic                             in_tuser,   // [0] cmd
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [11:0] temperature, [12] relay_on, [14:13] switch_event,
  // [46:15] previous_duration, [47] save_due
  output logic [aht_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [aht_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [aht_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import aht_pkg::*;

  aht_cmd_t cmd;
  aht_sts_t sts;

  assign cfg_ready = 1'b1;

  aht_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  aht_dpath #(
    .MAX_READS  (MAX_READS),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .sample_value ($signed(in_tdata[SAMPLE_W-1:0])),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_data     (out_tdata)
  );

endmodule

[rtl/aht_div.sv]
module aht_div #(
  parameter int NUM_W = 23,
  parameter int DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign fits    = (shifted >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      den_nxt  = divisor;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[rtl/aht_dpath.sv]
module aht_dpath #(
  parameter int MAX_READS  = 16,
  parameter int TICK_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  aht_pkg::aht_cmd_t                    cmd,
  output aht_pkg::aht_sts_t                    sts,
  input  logic signed [aht_pkg::SAMPLE_W-1:0]  sample_value,
  input  logic                                 cfg_we,
  input  logic [aht_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [aht_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic [aht_pkg::OUT_DATA_W-1:0]       out_data
);
  import aht_pkg::*;

  localparam int NW = $clog2(MAX_READS + 1);
  localparam int SW = SAMPLE_W + $clog2(MAX_READS) + 1;
  localparam int DW = $clog2(DIV_SCALE * MAX_READS + 1);
  localparam int TW = SW + 1;

  logic [NREADS_W-1:0]   num_reads_r;
  logic [TEMP_W-1:0]     min_temp_r;
  logic [TEMP_W-1:0]     max_temp_r;
  logic [CAL_W-1:0]      cal_r;
  logic [INTERVAL_W-1:0] save_interval_r;

  logic signed [SW-1:0]  sum_r, sum_nxt;
  logic [NW-1:0]         count_r, count_nxt;
  logic                  neg_r;
  logic                  relay_r, relay_nxt;
  logic [TICK_WIDTH-1:0] state_ticks_r, state_ticks_nxt;
  logic [TICK_WIDTH-1:0] save_ticks_r, save_ticks_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [NREADS_W-1:0]   nr_eff;
  logic [NW-1:0]         n_need;
  logic [DW-1:0]         den;
  logic [SW-1:0]         mag;
  logic [SW-1:0]         quo;
  logic signed [TW-1:0]  quo_s;
  logic signed [TW-1:0]  temp;
  logic signed [TW-1:0]  lo_x;
  logic signed [TW-1:0]  hi_x;
  logic [EVENT_W-1:0]    event_c;
  logic [63:0]           st64;
  logic [DUR_W-1:0]      dur;
  logic                  save_c;
  logic                  div_done;

  // readings needed per measurement, and the divisor scaled by DIV_SCALE
  always_comb begin
    nr_eff = (num_reads_r == '0) ? NUM_READS_DFLT : num_reads_r;
    if (32'(nr_eff) > 32'(MAX_READS)) begin
      n_need = NW'(MAX_READS);
    end else begin
      n_need = NW'(nr_eff);
    end
    den = DW'(32'(n_need) * DIV_SCALE);
  end

  assign sum_nxt       = sum_r + {{(SW-SAMPLE_W){sample_value[SAMPLE_W-1]}}, sample_value};
  assign count_nxt     = count_r + 1'b1;
  assign sts.meas_done = ({1'b0, count_r} + 1'b1) >= {1'b0, n_need};
  assign sts.div_done  = div_done;
  assign mag           = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);

  aht_div #(
    .NUM_W (SW),
    .DEN_W (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (mag),
    .divisor  (den),
    .done     (div_done),
    .quotient (quo)
  );

  // result, hysteresis and tick bookkeeping
  always_comb begin
    quo_s   = $signed({1'b0, quo});
    temp    = (neg_r ? -quo_s : quo_s) + {{(TW-CAL_W){cal_r[CAL_W-1]}}, cal_r};
    lo_x    = {{(TW-TEMP_W){min_temp_r[TEMP_W-1]}}, min_temp_r};
    hi_x    = {{(TW-TEMP_W){max_temp_r[TEMP_W-1]}}, max_temp_r};
    event_c = EV_NONE;
    relay_nxt = relay_r;
    if ((temp > hi_x) && relay_r) begin
      event_c = EV_OFF;
    end else if ((temp < lo_x) && !relay_r) begin
      event_c = EV_ON;
    end
    st64   = 64'(state_ticks_r);
    dur    = (event_c == EV_NONE) ? '0 :
             (st64 > 64'h0000_0000_FFFF_FFFF) ? '1 : st64[DUR_W-1:0];
    save_c = 64'(save_ticks_r) > 64'(save_interval_r);

    state_ticks_nxt = state_ticks_r;
    save_ticks_nxt  = save_ticks_r;
    out_data_nxt    = out_data_r;
    if (cmd.tick_en) begin
      if (state_ticks_r != '1) state_ticks_nxt = state_ticks_r + 1'b1;
      if (save_ticks_r != '1) save_ticks_nxt = save_ticks_r + 1'b1;
    end
    if (cmd.fin_load) begin
      if (event_c != EV_NONE) begin
        relay_nxt       = (event_c == EV_ON);
        state_ticks_nxt = '0;
      end
      if (save_c) save_ticks_nxt = '0;
      out_data_nxt = {save_c, dur, event_c, relay_nxt, temp[TEMP_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_reads_r     <= NUM_READS_RST;
      min_temp_r      <= MIN_TEMP_RST;
      max_temp_r      <= MAX_TEMP_RST;
      cal_r           <= CAL_RST;
      save_interval_r <= SAVE_INTERVAL_RST;
      sum_r           <= '0;
      count_r         <= '0;
      relay_r         <= 1'b0;
      state_ticks_r   <= '0;
      save_ticks_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_READS:     num_reads_r     <= cfg_data[NREADS_W-1:0];
          REG_MIN_TEMP:      min_temp_r      <= cfg_data[TEMP_W-1:0];
          REG_MAX_TEMP:      max_temp_r      <= cfg_data[TEMP_W-1:0];
          REG_CALIBRATION:   cal_r           <= cfg_data[CAL_W-1:0];
          REG_SAVE_INTERVAL: save_interval_r <= cfg_data[INTERVAL_W-1:0];
          default: ;
        endcase
      end
      if (cmd.read_en) begin
        sum_r   <= sum_nxt;
        count_r <= count_nxt;
      end else if (cmd.div_start) begin
        sum_r   <= '0;
        count_r <= '0;
      end
      relay_r       <= relay_nxt;
      state_ticks_r <= state_ticks_nxt;
      save_ticks_r  <= save_ticks_nxt;
    end
    if (cmd.div_start) neg_r <= sum_r[SW-1];
    out_data_r <= out_data_nxt;
  end

  assign out_data = out_data_r;

`ifndef SYNTHESIS
  a_relay_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    (relay_r != $past(relay_r)) |-> $past(cmd.fin_load))
    else $error("relay changed without a measurement");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(MAX_READS))
    else $error("reading count beyond limit");
  a_switch_clears_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin_load && (event_c != EV_NONE)) |=> (state_ticks_r == '0))
    else $error("state ticks not cleared on switch");
  a_start_clears_acc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> ((count_r == '0) && (sum_r == '0)))
    else $error("accumulator not cleared at divide start");
`endif

endmodule

[rtl/aht_ctrl.sv]
module aht_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_cmd,
  output logic              out_tvalid,
  input  logic              out_tready,
  output aht_pkg::aht_cmd_t cmd,
  input  aht_pkg::aht_sts_t sts
);
  import aht_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       acc;

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    cmd.tick_en   = acc && in_cmd;
    cmd.read_en   = acc && !in_cmd;
    cmd.div_start = 1'b0;
    cmd.fin_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (acc && !in_cmd && sts.meas_done) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!ovalid_r || out_tready) begin
          cmd.fin_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    ovalid_nxt = cmd.fin_load ? 1'b1 : (out_tready ? 1'b0 : ovalid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_tvalid = ovalid_r;

`ifndef SYNTHESIS
  a_div_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIV) && sts.div_done) |=> (state_r == S_FIN))
    else $error("divide done not followed by finish");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_load |-> (!ovalid_r || out_tready))
    else $error("pending result overwritten");
  a_load_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> ($past(state_r) == S_IDLE))
    else $error("divide load not entered from idle");
`endif

endmodule

[test/tb_averaging_hysteresis_thermostat_unit.sv]
`timescale 1ns / 100ps

module tb_averaging_hysteresis_thermostat_unit;
  import aht_pkg::*;

  localparam int MAX_READS   = 16;
  localparam int TICK_WIDTH  = 32;
  localparam int PHASE_ITEMS = 166;
  localparam int SETTLE_CYC  = 40;
  localparam int CYCLE_LIMIT = 1_000_000;

  // packs exactly like out_tdata, save_due in the top bit
  typedef struct packed {
    logic                save_due;
    logic [DUR_W-1:0]    duration;
    logic [EVENT_W-1:0]  sw_event;
    logic                relay_on;
    logic [TEMP_W-1:0]   temperature;
  } thermo_result_t;

  class thermo_scoreboard;
    logic [NREADS_W-1:0]      num_reads;
    logic signed [TEMP_W-1:0] min_temp;
    logic signed [TEMP_W-1:0] max_temp;
    logic signed [CAL_W-1:0]  calib;
    logic [INTERVAL_W-1:0]    save_interval;
    longint                   reading_sum;
    int                       reading_count;
    logic                     relay;
    logic [TICK_WIDTH-1:0]    state_ticks;
    logic [TICK_WIDTH-1:0]    save_ticks;
    thermo_result_t           expected_q[$];
    int                       errors;

    function new();
      num_reads     = NUM_READS_RST;
      min_temp      = MIN_TEMP_RST;
      max_temp      = MAX_TEMP_RST;
      calib         = CAL_RST;
      save_interval = SAVE_INTERVAL_RST;
      reading_sum   = 0;
      reading_count = 0;
      relay         = 1'b0;
      state_ticks   = '0;
      save_ticks    = '0;
      errors        = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_NUM_READS:     num_reads     = data[NREADS_W-1:0];
        REG_MIN_TEMP:      min_temp      = data[TEMP_W-1:0];
        REG_MAX_TEMP:      max_temp      = data[TEMP_W-1:0];
        REG_CALIBRATION:   calib         = data[CAL_W-1:0];
        REG_SAVE_INTERVAL: save_interval = data[INTERVAL_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic cmd, logic [SAMPLE_W-1:0] reading);
      int             needed;
      longint         temp;
      longint         lo;
      longint         hi;
      thermo_result_t r;
      if (cmd) begin
        if (state_ticks != '1) state_ticks++;
        if (save_ticks != '1) save_ticks++;
        return;
      end
      reading_sum += longint'($signed(reading));
      reading_count++;
      needed = (num_reads == 0) ? int'(NUM_READS_DFLT) :
               (num_reads > MAX_READS) ? MAX_READS : int'(num_reads);
      if (reading_count < needed) return;
      temp = reading_sum / (longint'(DIV_SCALE) * needed) + longint'(calib);
      reading_sum   = 0;
      reading_count = 0;
      lo = longint'(min_temp);
      hi = longint'(max_temp);
      r = '0;
      if (temp > hi && relay) begin
        relay = 1'b0;
        r.sw_event = EV_OFF;
      end else if (temp < lo && !relay) begin
        relay = 1'b1;
        r.sw_event = EV_ON;
      end
      if (r.sw_event != EV_NONE) begin
        r.duration  = state_ticks;
        state_ticks = '0;
      end
      if (save_ticks > save_interval) begin
        r.save_due = 1'b1;
        save_ticks = '0;
      end
      r.temperature = temp[TEMP_W-1:0];
      r.relay_on    = relay;
      expected_q.push_back(r);
    endfunction

    function void check_field(string name, longint exp_val, longint got_val);
      if (exp_val != got_val) begin
        errors++;
        $error("%s: expected %0d, actual %0d", name, exp_val, got_val);
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      thermo_result_t got;
      thermo_result_t exp_r;
      got = data;
      if (expected_q.size() == 0) begin
        errors++;
        $error("result with nothing expected: %h", data);
        return;
      end
      exp_r = expected_q.pop_front();
      check_field("temperature", $signed(exp_r.temperature), $signed(got.temperature));
      check_field("relay_on", exp_r.relay_on, got.relay_on);
      check_field("switch_event", exp_r.sw_event, got.sw_event);
      check_field("previous_duration", exp_r.duration, got.duration);
      check_field("save_due", exp_r.save_due, got.save_due);
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata;
  logic                    in_tuser;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [REG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  thermo_scoreboard thermo;
  int               cycle_count = 0;
  bit               hold_request = 1'b0;
  int               hold_left = 0;

  averaging_hysteresis_thermostat_unit #(
    .MAX_READS (MAX_READS),
    .TICK_WIDTH(TICK_WIDTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) thermo.check_result(out_tdata);
  end

  // result side back-pressure; a long hold-off on request
  always @(negedge clk) begin
    if (hold_request && hold_left == 0) begin
      hold_left = 600;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case ((cycle_count >> 7) % 4)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 1) == 1);
        2:       out_tready <= (cycle_count % 7 > 2);
        default: out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(bit cmd, int value);
    logic [SAMPLE_W-1:0] reading;
    reading = value[SAMPLE_W-1:0];
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_DATA_W-SAMPLE_W){1'b0}}, reading};
    do @(posedge clk); while (!in_tready);
    thermo.note_request(cmd, reading);
    @(negedge clk);
  endtask

  task automatic load_register(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value,
                               int width);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom;
    for (int b = 0; b < width; b++) data[b] = value[b];
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    thermo.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (thermo.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic run_phase(logic [NREADS_W-1:0] nr, int lo, int hi, int cal,
                           logic [INTERVAL_W-1:0] interval, bit pressure);
    int n_eff;
    int burst_left;
    int gap;
    int gen_count;
    int target;
    int value;
    int pick;
    settle();
    load_register(REG_NUM_READS, nr, NREADS_W);
    load_register(REG_MIN_TEMP, lo, TEMP_W);
    load_register(REG_MAX_TEMP, hi, TEMP_W);
    load_register(REG_CALIBRATION, cal, CAL_W);
    load_register(REG_SAVE_INTERVAL, interval, INTERVAL_W);
    load_register(REG_IDX_W'(REG_SAVE_INTERVAL + $urandom_range(1, 3)), $urandom, CFG_DATA_W);
    cfg_valid <= 1'b0;
    if (pressure) hold_request = 1'b1;
    n_eff = (nr == 0) ? int'(NUM_READS_DFLT) : (nr > MAX_READS) ? MAX_READS : int'(nr);
    burst_left = 0;
    gen_count = 0;
    target = lo;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_item(1'b1, $urandom);
      end else begin
        if (gen_count % n_eff == 0)
          target = (($urandom_range(0, 1) == 1) ? hi : lo) - cal +
                   int'($urandom_range(0, 80)) - 40;
        gen_count++;
        if (pick < 80) begin
          value = target * DIV_SCALE + int'($urandom_range(0, 1000)) - 500;
          if (value > 131071) value = 131071;
          if (value < -131072) value = -131072;
        end else begin
          value = $urandom;
        end
        send_item(1'b0, value);
      end
    end
  endtask

  initial begin
    int lo;
    int hi;
    int cal;
    thermo     = new();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ticks ignore the reading field
    send_item(1'b1, 'h3FFFF);
    send_item(1'b1, 0);
    // hot while off: no switch
    repeat (4) send_item(1'b0, 125000);
    // cold: turns on
    repeat (4) send_item(1'b0, -55000);
    // largest reading: turns off
    repeat (4) send_item(1'b0, 'h1FFFF);
    // count lowered while readings are held
    repeat (3) send_item(1'b0, 20000);
    settle();
    load_register(REG_NUM_READS, 2, NREADS_W);
    cfg_valid <= 1'b0;
    send_item(1'b0, 20000);
    // zero save interval, smallest reading
    settle();
    load_register(REG_SAVE_INTERVAL, 0, INTERVAL_W);
    cfg_valid <= 1'b0;
    send_item(1'b1, 0);
    repeat (2) send_item(1'b0, 'h20000);

    run_phase(5'd1, -550, 1250, -500, 32'd0, 1'b1);
    run_phase(5'd16, 1250, -550, 0, 32'd5, 1'b0);
    run_phase(5'd0, 150, 250, 511, 32'hFFFF_FFFF, 1'b0);
    run_phase(5'd31, -2048, 2047, -512, 32'd3, 1'b0);
    for (int p = 0; p < 4; p++) begin
      lo = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 4095)) - 2048 :
           int'($urandom_range(0, 1800)) - 550;
      hi = lo + int'($urandom_range(0, 300));
      if (hi > 2047) hi = 2047;
      cal = int'($urandom_range(0, 1023)) - 512;
      run_phase(NREADS_W'($urandom_range(0, 31)), lo, hi, cal,
                ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 60), 1'b0);
    end

    in_tvalid <= 1'b0;
    while (thermo.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (thermo.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/aht_pkg.sv
rtl/aht_div.sv
rtl/aht_dpath.sv
rtl/aht_ctrl.sv
rtl/averaging_hysteresis_thermostat_unit.sv
test/tb_averaging_hysteresis_thermostat_unit.sv
